[sv/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising edge out of reset
`define SFE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition that must never be seen out of reset
`define SFE_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SFE_ASSERT(lbl, clk, rstn, prop, msg)
`define SFE_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

[sv/sfe_pkg.sv]
`default_nettype none
package sfe_pkg;

  localparam int CHAR_W  = 8;
  localparam int MAX_RUN = 10;
  localparam int CNT_W   = $clog2(MAX_RUN + 1);
  localparam int SUM_W   = 12;

  // framing characters and the address offset base
  localparam logic [CHAR_W-1:0] CH_HASH = 8'd35;
  localparam logic [CHAR_W-1:0] CH_EQ   = 8'd61;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'd13;
  localparam logic [CHAR_W-1:0] CH_A    = 8'd97;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [3:0][CHAR_W-1:0] group_t;

  // characters of one item plus how many of them are valid
  typedef struct packed {
    logic [MAX_RUN-1:0][CHAR_W-1:0] chars;
    logic [CNT_W-1:0]               count;
  } run_t;

  // three bytes to four offset six-bit characters, first character in slot 0
  function automatic group_t enc_group(input char_t a, input char_t b, input char_t c);
    group_t g;
    g[0] = CH_EQ + {2'b00, a[7:2]};
    g[1] = CH_EQ + {2'b00, a[1:0], b[7:4]};
    g[2] = CH_EQ + {2'b00, b[3:0], c[7:6]};
    g[3] = CH_EQ + {2'b00, c[5:0]};
    return g;
  endfunction

endpackage
`default_nettype wire

[sv/sfe_encode.sv]
`default_nettype none
`include "assert_macros.svh"
module sfe_encode
  import sfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_xfer,
  input  wire logic [7:0]  payload_byte,
  input  wire logic        byte_present,
  input  wire logic        frame_last,
  input  wire logic [7:0]  command_code,
  input  wire logic [7:0]  dest_address,
  output run_t             run
);

  logic             in_frame_r, in_frame_nxt;
  logic [15:0]      grp_r, grp_nxt;
  logic [1:0]       gcnt_r, gcnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  logic             hdr;
  logic [15:0]      gb0, gb1;
  logic [1:0]       gc0, gc1;
  logic [SUM_W-1:0] sum0, sum1, hdr_sum, grp_sum;
  char_t            addr_ch, ga, gbb, gcc;
  logic             grp_emit;
  group_t           grp;
  logic [CNT_W-1:0] n;

  // header, pending group bookkeeping and group selection
  always_comb begin
    hdr     = !in_frame_r;
    gb0     = hdr ? 16'h0000 : grp_r;
    gc0     = hdr ? 2'd0 : gcnt_r;
    sum0    = hdr ? '0 : sum_r;
    addr_ch = CH_A + dest_address;
    hdr_sum = SUM_W'(CH_HASH) + SUM_W'(addr_ch) + SUM_W'(command_code);

    grp_emit = 1'b0;
    ga       = gb0[15:8];
    gbb      = gb0[7:0];
    gcc      = payload_byte;
    gb1      = gb0;
    gc1      = gc0;
    if (byte_present) begin
      case (gc0)
        2'd0: begin
          gb1 = {payload_byte, 8'h00};
          gc1 = 2'd1;
        end
        2'd1: begin
          gb1 = {gb0[15:8], payload_byte};
          gc1 = 2'd2;
        end
        default: begin
          grp_emit = 1'b1;
          gb1      = 16'h0000;
          gc1      = 2'd0;
        end
      endcase
    end
    // short group padded with zero bytes at frame end
    if (frame_last && gc1 != 2'd0) begin
      grp_emit = 1'b1;
      ga       = gb1[15:8];
      gbb      = (gc1 == 2'd1) ? 8'h00 : gb1[7:0];
      gcc      = 8'h00;
    end
  end

  assign grp     = enc_group(ga, gbb, gcc);
  assign grp_sum = SUM_W'(grp[0]) + SUM_W'(grp[1]) + SUM_W'(grp[2]) + SUM_W'(grp[3]);
  assign sum1    = sum0 + (hdr ? hdr_sum : '0) + (grp_emit ? grp_sum : '0);

  // character list of this item
  always_comb begin
    run.chars = '0;
    n         = '0;
    if (hdr) begin
      run.chars[0] = CH_HASH;
      run.chars[1] = addr_ch;
      run.chars[2] = command_code;
      n            = CNT_W'(3);
    end
    if (grp_emit) begin
      for (int i = 0; i < 4; i++) begin
        run.chars[n + CNT_W'(i)] = grp[i];
      end
      n = n + CNT_W'(4);
    end
    if (frame_last) begin
      run.chars[n]              = CH_EQ + {2'b00, sum1[11:6]};
      run.chars[n + CNT_W'(1)]  = CH_EQ + {2'b00, sum1[5:0]};
      run.chars[n + CNT_W'(2)]  = CH_CR;
      n                         = n + CNT_W'(3);
    end
    run.count = n;
  end

  // frame state after this item
  always_comb begin
    if (frame_last) begin
      in_frame_nxt = 1'b0;
      grp_nxt      = 16'h0000;
      gcnt_nxt     = 2'd0;
      sum_nxt      = '0;
    end else begin
      in_frame_nxt = 1'b1;
      grp_nxt      = gb1;
      gcnt_nxt     = gc1;
      sum_nxt      = sum1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      grp_r      <= 16'h0000;
      gcnt_r     <= 2'd0;
      sum_r      <= '0;
    end else if (in_xfer) begin
      in_frame_r <= in_frame_nxt;
      grp_r      <= grp_nxt;
      gcnt_r     <= gcnt_nxt;
      sum_r      <= sum_nxt;
    end
  end

  `SFE_NEVER(a_gcnt_max, clk, rst_n, gcnt_r == 2'd3, "pending byte count reached three")
  `SFE_ASSERT(a_closed_clean, clk, rst_n, !in_frame_r |-> (gcnt_r == 2'd0 && sum_r == '0), "closed frame left state behind")

endmodule
`default_nettype wire

[sv/sfe_serialize.sv]
`default_nettype none
`include "assert_macros.svh"
module sfe_serialize
  import sfe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  load,
  input  wire run_t  run,
  output logic       can_load,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_tx_char,
  output logic       out_run_last
);

  logic [MAX_RUN-1:0][CHAR_W-1:0] chars_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           out_xfer;

  assign out_valid    = (cnt_r != '0);
  assign out_xfer     = out_valid && out_ready;
  assign out_tx_char  = chars_r[0];
  assign out_run_last = (cnt_r == CNT_W'(1));
  // buffer free, or its last character leaves this cycle
  assign can_load     = (cnt_r == '0) || (out_run_last && out_ready);

  // remaining character count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= run.count;
    end else if (out_xfer) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // character shift line, head at slot 0
  always_ff @(posedge clk) begin
    if (load) begin
      chars_r <= run.chars;
    end else if (out_xfer) begin
      chars_r <= {CHAR_W'(0), chars_r[MAX_RUN-1:1]};
    end
  end

  `SFE_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= CNT_W'(MAX_RUN),
    "character count above run maximum")
  `SFE_ASSERT(a_load_safe, clk, rst_n,
    load |-> (cnt_r == '0 || (cnt_r == CNT_W'(1) && out_ready)),
    "run loaded over pending characters")
  `SFE_ASSERT(a_cnt_step, clk, rst_n,
    (out_xfer && !load && cnt_r > CNT_W'(1)) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)),
    "count did not step down on transfer")

endmodule
`default_nettype wire

[sv/serial_frame_encoder_sum_checksum.sv]
// channel  ports                                                 direction
// in       in_valid in_ready in_payload_byte .. in_dest_address  input
// out      out_valid out_ready out_tx_char out_run_last          output
//
// an item causing k characters holds the output buffer until all k have transferred,
// one character per cycle while out_ready is high; an item causing none leaves it free
// the next item is taken in the cycle its predecessor's last character transfers
// encoding is one combinational pass into the output shift buffer
// rst_n is synchronous, active low, and closes any open frame
// out_ready low holds the current character and stalls the input side while characters are pending
`default_nettype none
module serial_frame_encoder_sum_checksum
  import sfe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_payload_byte,
  input  wire logic       in_byte_present,
  input  wire logic       in_frame_last,
  input  wire logic [7:0] in_command_code,
  input  wire logic [7:0] in_dest_address,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_tx_char,
  output logic            out_run_last
);

  run_t run;
  logic in_xfer;
  logic can_load;

  assign in_ready = can_load;
  assign in_xfer  = in_valid && can_load;

  // frame state and character generation
  sfe_encode u_encode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_xfer      (in_xfer),
    .payload_byte (in_payload_byte),
    .byte_present (in_byte_present),
    .frame_last   (in_frame_last),
    .command_code (in_command_code),
    .dest_address (in_dest_address),
    .run          (run)
  );

  // one character per transfer
  sfe_serialize u_serialize (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (in_xfer),
    .run          (run),
    .can_load     (can_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_tx_char  (out_tx_char),
    .out_run_last (out_run_last)
  );

endmodule
`default_nettype wire
